>>> hw/rtl/bclru_pkg.sv
// Shared types and constants for the byte budget LRU cache.
package bclru_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_INSERT    = 2'd1,
    CMD_CLEAR_ALL = 2'd2,
    CMD_CLEAR_ID  = 2'd3
  } cmd_e;

  // One table row: key, size and handle.
  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] size;
    logic [12:0] height;
    logic [12:0] width;
    logic [63:0] ts;
    logic [31:0] media;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

>>> hw/rtl/bclru_ram.sv
// Simple dual port RAM with one write port and one registered read port.
module bclru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/byte_budget_lru_cache_unit.sv
// Byte budget LRU cache: top level with sequencer, link list and slot RAMs.
// A lookup scans all slots; a hit ends the scan at its slot and moves that slot to the head.
// A clear by media id scans all slots and drops each matching slot. An insert scans all slots,
// then drops a same key slot or, in a full table, the tail, and evicts from the tail while
// over budget; refused inserts and clear all do not scan. One word is in work at a time.
// Reset (rst_ni low, asynchronous) empties the table and zeroes bytes, counters and budget.
module byte_budget_lru_cache_unit #(
  parameter int unsigned TABLE_ENTRIES = bclru_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input words. tdata from bit 0: media_id, timestamp, target_width,
  // target_height, entry_bytes, frame_handle, zero fill.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [191:0] s_axis_tdata_i,
  // tuser: cmd.
  input  logic [1:0]   s_axis_tuser_i,
  // Result words. tdata from bit 0: hit, accepted, found_handle, removed_count,
  // entries_used, bytes_used, total_hits, total_evictions.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [143:0] m_axis_tdata_o,
  // Budget register write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_UL_RD, S_UL_WR, S_FULLCHK, S_FILL, S_PUSH, S_BUDGET, S_OUT
  } state_e;

  // What the current unlink belongs to, which picks the follow-up step.
  typedef enum logic [2:0] {
    P_LOOKUP, P_SAMEKEY, P_FULL, P_BUDGET, P_MEDIA
  } phase_e;

  state_e                  state_q;
  phase_e                  phase_q;
  bclru_pkg::cmd_e         cmd_q;
  bclru_pkg::row_t         req_q;
  logic [31:0]             budget_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           removed_q;
  logic [32:0]             bytes_q;
  logic [31:0]             hits_q;
  logic [31:0]             evict_q;
  logic [IW-1:0]           head_q;
  logic [IW-1:0]           tail_q;
  logic [IW-1:0]           tgt_q;
  logic [IW:0]             idx_q;
  logic                    pend_q;
  logic [IW-1:0]           pidx_q;
  logic [IW-1:0]           fr_q;
  logic                    fr_ok_q;
  logic                    same_q;
  logic [IW-1:0]           same_idx_q;
  logic                    hit_q;
  logic                    acc_q;
  logic [31:0]             found_q;
  logic                    out_valid_q;
  logic [143:0]            out_data_q;

  bclru_pkg::row_t         in_row;
  bclru_pkg::row_t         row_rd;
  logic [bclru_pkg::ROW_W-1:0] row_rd_raw;
  logic [IW-1:0]           row_raddr;
  logic                    row_we;

  logic [IW-1:0]           prev_rd;
  logic [IW-1:0]           next_rd;
  logic                    next_we;
  logic [IW-1:0]           next_waddr;
  logic [IW-1:0]           next_wdata;
  logic                    prev_we;
  logic [IW-1:0]           prev_waddr;
  logic [IW-1:0]           prev_wdata;

  logic                    key_hit;
  logic                    media_hit;
  logic                    chk_valid;
  logic [32:0]             bytes_after_drop;
  logic                    scan_done;

  // Unpack the input word.
  assign in_row.media  = s_axis_tdata_i[31:0];
  assign in_row.ts     = s_axis_tdata_i[95:32];
  assign in_row.width  = s_axis_tdata_i[108:96];
  assign in_row.height = s_axis_tdata_i[121:109];
  assign in_row.size   = s_axis_tdata_i[153:122];
  assign in_row.handle = s_axis_tdata_i[185:154];

  assign row_rd = bclru_pkg::row_t'(row_rd_raw);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The slot checked in a scan cycle is the one whose row was read the cycle before.
  assign chk_valid = pend_q && valid_q[pidx_q];
  assign media_hit = chk_valid && (row_rd.media == req_q.media);
  assign key_hit   = media_hit && (row_rd.ts == req_q.ts) &&
                     (row_rd.width == req_q.width) && (row_rd.height == req_q.height);
  assign scan_done = !pend_q && (idx_q == (IW+1)'(TABLE_ENTRIES));

  // Dropping a slot takes its size off the total, never going below zero.
  assign bytes_after_drop = (bytes_q < {1'b0, row_rd.size}) ? 33'd0 :
                            bytes_q - {1'b0, row_rd.size};

  // Memory port control. The recency order is a doubly linked list from head
  // (most recent) to tail (least recent), kept in the prev and next RAMs.
  always_comb begin
    row_we     = (state_q == S_FILL);
    row_raddr  = (state_q == S_SCAN) ? idx_q[IW-1:0] : tgt_q;
    next_we    = 1'b0;
    next_waddr = tgt_q;
    next_wdata = head_q;
    prev_we    = 1'b0;
    prev_waddr = head_q;
    prev_wdata = tgt_q;
    case (state_q)
      S_UL_WR: begin
        next_we    = (tgt_q != head_q);
        next_waddr = prev_rd;
        next_wdata = next_rd;
        prev_we    = (tgt_q != tail_q);
        prev_waddr = next_rd;
        prev_wdata = prev_rd;
      end
      S_PUSH: begin
        next_we = 1'b1;
        prev_we = (count_q != '0);
      end
      default: begin
      end
    endcase
  end

  bclru_ram #(.WIDTH(bclru_pkg::ROW_W), .DEPTH(TABLE_ENTRIES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (fr_q),
    .wdata_i (req_q),
    .raddr_i (row_raddr),
    .rdata_o (row_rd_raw)
  );

  bclru_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (tgt_q),
    .rdata_o (next_rd)
  );

  bclru_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (tgt_q),
    .rdata_o (prev_rd)
  );

  // Sequencer. Each step either scans one slot, works on the linked list, or
  // evicts the tail slot; the result word is loaded once the item is finished.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_LOOKUP;
      cmd_q       <= bclru_pkg::CMD_LOOKUP;
      budget_q    <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      removed_q   <= '0;
      bytes_q     <= '0;
      hits_q      <= '0;
      evict_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      tgt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      fr_q        <= '0;
      fr_ok_q     <= 1'b0;
      same_q      <= 1'b0;
      same_idx_q  <= '0;
      hit_q       <= 1'b0;
      acc_q       <= 1'b0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      req_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        budget_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q     <= bclru_pkg::cmd_e'(s_axis_tuser_i);
            req_q     <= in_row;
            hit_q     <= 1'b0;
            acc_q     <= 1'b0;
            found_q   <= '0;
            removed_q <= '0;
            fr_ok_q   <= 1'b0;
            same_q    <= 1'b0;
            idx_q     <= '0;
            pend_q    <= 1'b0;
            state_q   <= S_OUT;
            case (bclru_pkg::cmd_e'(s_axis_tuser_i))
              bclru_pkg::CMD_LOOKUP: begin
                state_q <= S_SCAN;
              end
              bclru_pkg::CMD_INSERT: begin
                // Refused inserts leave everything as it is.
                if (budget_q != '0 && in_row.size != '0 && in_row.size <= budget_q &&
                    in_row.media != '0) begin
                  state_q <= S_SCAN;
                end
              end
              bclru_pkg::CMD_CLEAR_ALL: begin
                valid_q   <= '0;
                count_q   <= '0;
                bytes_q   <= '0;
                removed_q <= count_q;
              end
              bclru_pkg::CMD_CLEAR_ID: begin
                if (in_row.media != '0) begin
                  state_q <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue the read of the next slot while checking the previous one.
          if (idx_q != (IW+1)'(TABLE_ENTRIES)) begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[IW-1:0];
            idx_q  <= idx_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          case (cmd_q)
            bclru_pkg::CMD_LOOKUP: begin
              if (key_hit) begin
                hit_q   <= 1'b1;
                found_q <= row_rd.handle;
                hits_q  <= hits_q + 32'd1;
                tgt_q   <= pidx_q;
                phase_q <= P_LOOKUP;
                state_q <= S_UL_RD;
              end else if (scan_done) begin
                state_q <= S_OUT;
              end
            end
            bclru_pkg::CMD_INSERT: begin
              // Remember the lowest free slot and any slot with the same key.
              if (pend_q && !valid_q[pidx_q] && !fr_ok_q) begin
                fr_q    <= pidx_q;
                fr_ok_q <= 1'b1;
              end
              if (key_hit) begin
                same_q     <= 1'b1;
                same_idx_q <= pidx_q;
              end
              if (scan_done) begin
                if (same_q) begin
                  tgt_q   <= same_idx_q;
                  phase_q <= P_SAMEKEY;
                  state_q <= S_UL_RD;
                  if (!fr_ok_q || same_idx_q < fr_q) begin
                    fr_q    <= same_idx_q;
                    fr_ok_q <= 1'b1;
                  end
                end else begin
                  state_q <= S_FULLCHK;
                end
              end
            end
            default: begin
              // Clear by media id: drop each match, then rescan from the next slot.
              if (media_hit) begin
                tgt_q     <= pidx_q;
                removed_q <= removed_q + 1'b1;
                idx_q     <= {1'b0, pidx_q} + 1'b1;
                pend_q    <= 1'b0;
                phase_q   <= P_MEDIA;
                state_q   <= S_UL_RD;
              end else if (scan_done) begin
                state_q <= S_OUT;
              end
            end
          endcase
        end

        S_UL_RD: begin
          state_q <= S_UL_WR;
        end

        S_UL_WR: begin
          if (tgt_q == head_q) begin
            head_q <= next_rd;
          end
          if (tgt_q == tail_q) begin
            tail_q <= prev_rd;
          end
          count_q <= count_q - 1'b1;
          if (phase_q != P_LOOKUP) begin
            valid_q[tgt_q] <= 1'b0;
            bytes_q        <= bytes_after_drop;
          end
          case (phase_q)
            P_LOOKUP:  state_q <= S_PUSH;
            P_SAMEKEY: state_q <= S_FULLCHK;
            P_FULL:    state_q <= S_FILL;
            P_BUDGET:  state_q <= S_BUDGET;
            default:   state_q <= S_SCAN;
          endcase
        end

        S_FULLCHK: begin
          if (count_q >= CW'(TABLE_ENTRIES)) begin
            tgt_q     <= tail_q;
            removed_q <= removed_q + 1'b1;
            evict_q   <= evict_q + 32'd1;
            phase_q   <= P_FULL;
            state_q   <= S_UL_RD;
            if (!fr_ok_q || tail_q < fr_q) begin
              fr_q    <= tail_q;
              fr_ok_q <= 1'b1;
            end
          end else begin
            state_q <= S_FILL;
          end
        end

        S_FILL: begin
          tgt_q   <= fr_q;
          bytes_q <= bytes_q + {1'b0, req_q.size};
          acc_q   <= 1'b1;
          state_q <= S_PUSH;
        end

        S_PUSH: begin
          head_q         <= tgt_q;
          valid_q[tgt_q] <= 1'b1;
          count_q        <= count_q + 1'b1;
          if (count_q == '0) begin
            tail_q <= tgt_q;
          end
          state_q <= (cmd_q == bclru_pkg::CMD_INSERT) ? S_BUDGET : S_OUT;
        end

        S_BUDGET: begin
          if (bytes_q > {1'b0, budget_q} && count_q != '0) begin
            tgt_q     <= tail_q;
            removed_q <= removed_q + 1'b1;
            evict_q   <= evict_q + 32'd1;
            phase_q   <= P_BUDGET;
            state_q   <= S_UL_RD;
          end else begin
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {evict_q, hits_q, bytes_q[31:0], 7'(count_q), 7'(removed_q),
                            found_q, acc_q, hit_q};
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("valid slot count exceeds table size");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(valid_q) == int'(count_q))
    else $error("slot count disagrees with valid bits");

  a_hits_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q != $past(hits_q) |-> hits_q == $past(hits_q) + 32'd1 && hit_q)
    else $error("hit counter moved without a hit");
`endif

endmodule
